// ----- sv/rational_arith_reduce_top_macros.svh -----
// Assertion macros shared by the rational fraction reducer RTL
`ifndef RATIONAL_ARITH_REDUCE_TOP_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define RAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rar_pkg.sv -----
// Shared types and codes for the rational fraction reducer
`default_nettype none

package rar_pkg;

    localparam int DATA_BITS = 32;

    typedef logic [1:0]                  t_func;
    typedef logic signed [DATA_BITS-1:0] t_data;
    typedef logic [1:0]                  t_status;

    localparam t_func FUNC_ADD = 2'd0;
    localparam t_func FUNC_SUB = 2'd1;
    localparam t_func FUNC_MUL = 2'd2;
    localparam t_func FUNC_DIV = 2'd3;

    localparam t_status STATUS_OK  = 2'd0;
    localparam t_status STATUS_ERR = 2'd1;
    localparam t_status STATUS_OVF = 2'd2;

endpackage

`default_nettype wire

// ----- sv/rar_if.sv -----
// Valid/ready channel interfaces for operand words and result words
`default_nettype none

interface rar_in_if;
    logic            valid;
    logic            ready;
    rar_pkg::t_func  func;
    rar_pkg::t_data  a_num;
    rar_pkg::t_data  a_den;
    rar_pkg::t_data  b_num;
    rar_pkg::t_data  b_den;

    modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
    logic             valid;
    logic             ready;
    rar_pkg::t_data   res_num;
    rar_pkg::t_data   res_den;
    rar_pkg::t_status status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

`default_nettype wire

// ----- sv/rational_arith_reduce_top.sv -----
// Rational fraction add/sub/mul/div with GCD reduction on one shared add/subtract unit.
//
// Up to three products come from one WORD_BITS multiplier, one per cycle (two for
// multiply and divide, three for add and subtract), followed for add and subtract by
// the sign-magnitude sum in S_ADD and, when the second term is larger, S_ADD2. The
// binary GCD takes one shift, subtract or swap step per cycle, at most about 4*MW
// steps: each shift or subtract drops a bit from one operand and a swap never follows a
// swap. The two restoring divisions by the GCD, numerator (S_DIVN) then denominator
// (S_DIVD), each run over all MW bits. The GCD and the divisions run through one MW+1
// bit add/subtract unit, MW = 2*WORD_BITS. Words with a zero denominator, or a divide
// by a zero b_num, skip straight to the result (status 1). i_in.ready is high only
// while the block is idle; a finished result waits in the output register, and the
// next word can be taken meanwhile; a result that finds the register still full holds
// the sequencer until o_out.ready. Results are WORD_BITS two's complement values,
// zero-extended to 32 bits; signs are kept as computed.
`default_nettype none

`include "rational_arith_reduce_top_macros.svh"

module rational_arith_reduce_top #(
    parameter int WORD_BITS = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rar_in_if.sink    i_in,
    rar_out_if.source o_out
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2 * WORD_BITS;
    localparam int CW = $clog2(MW);
    localparam int DB = rar_pkg::DATA_BITS;
    localparam logic [MW-1:0] HALF = MW'(1) << (WORD_BITS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_ADD   = 4'd4;
    localparam logic [3:0] S_ADD2  = 4'd5;
    localparam logic [3:0] S_GINIT = 4'd6;
    localparam logic [3:0] S_GCD   = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_DIVN  = 4'd9;
    localparam logic [3:0] S_DIVD  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    typedef struct packed {
        logic         neg;
        logic [W-1:0] mag;
    } t_smag;

    function automatic t_smag from_word(input rar_pkg::t_data raw);
        t_smag        r;
        logic [W-1:0] v;
        v     = raw[W-1:0];
        r.neg = v[W-1];
        r.mag = v[W-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    logic [3:0]       r_state, n_state;
    rar_pkg::t_func   r_func, n_func;
    t_smag            r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic [MW-1:0]    r_num_mag, n_num_mag, r_t2_mag, n_t2_mag, r_den_mag, n_den_mag;
    logic             r_num_neg, n_num_neg, r_t2_neg, n_t2_neg, r_den_neg, n_den_neg;
    logic [MW-1:0]    r_u, n_u, r_v, n_v, r_g, n_g, r_rem, n_rem, r_quo, n_quo;
    logic [CW-1:0]    r_k, n_k, r_cnt, n_cnt;
    logic             r_err, n_err;
    logic             r_out_valid, n_out_valid;
    rar_pkg::t_data   r_res_num, n_res_num, r_res_den, n_res_den;
    rar_pkg::t_status r_status, n_status;

    t_smag            in_an, in_ad, in_bn, in_bd;
    logic             in_fire;
    t_smag            mul_a, mul_b;
    logic [MW-1:0]    mul_p;
    logic             mul_neg;
    logic [MW-1:0]    alu_a, alu_b, alu_v;
    logic             alu_sub, alu_c;
    logic [MW:0]      alu_res;
    logic [MW-1:0]    div_trial, div_rem, div_quo;
    logic             num_fits, den_fits;
    logic [W-1:0]     num_w, den_w;

    assign in_an   = from_word(i_in.a_num);
    assign in_ad   = from_word(i_in.a_den);
    assign in_bn   = from_word(i_in.b_num);
    assign in_bd   = from_word(i_in.b_den);
    assign in_fire = i_in.valid && (r_state == S_IDLE);

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.res_num   = r_res_num;
    assign o_out.res_den   = r_res_den;
    assign o_out.status    = r_status;

    // Shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_MUL0: begin
                mul_a = r_an;
                mul_b = (r_func == rar_pkg::FUNC_MUL) ? r_bn : r_bd;
            end
            S_MUL1: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            default: begin
                mul_a = r_ad;
                mul_b = (r_func == rar_pkg::FUNC_DIV) ? r_bn : r_bd;
            end
        endcase
    end

    assign mul_p   = MW'(mul_a.mag) * MW'(mul_b.mag);
    assign mul_neg = (mul_a.neg ^ mul_b.neg) && (mul_p != '0);

    // Divider trial remainder: shift in the next dividend bit
    assign div_trial = {r_rem[MW-2:0], r_quo[MW-1]};

    // Shared add/subtract unit; bit MW is carry on add, borrow on subtract
    always_comb begin
        unique case (r_state) inside
            S_ADD: begin
                alu_a   = r_num_mag;
                alu_b   = r_t2_mag;
                alu_sub = (r_num_neg != r_t2_neg);
            end
            S_ADD2: begin
                alu_a   = r_t2_mag;
                alu_b   = r_num_mag;
                alu_sub = 1'b1;
            end
            S_GCD: begin
                alu_a   = r_u;
                alu_b   = r_v;
                alu_sub = 1'b1;
            end
            S_DIVN, S_DIVD: begin
                alu_a   = div_trial;
                alu_b   = r_g;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = r_num_mag;
                alu_b   = r_t2_mag;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});
    assign alu_c   = alu_res[MW];
    assign alu_v   = alu_res[MW-1:0];

    assign div_rem = alu_c ? div_trial : alu_v;
    assign div_quo = {r_quo[MW-2:0], ~alu_c};

    assign num_fits = r_num_neg ? (r_num_mag <= HALF) : (r_num_mag < HALF);
    assign den_fits = r_den_neg ? (r_den_mag <= HALF) : (r_den_mag < HALF);
    assign num_w    = r_num_neg ? (~r_num_mag[W-1:0] + 1'b1) : r_num_mag[W-1:0];
    assign den_w    = r_den_neg ? (~r_den_mag[W-1:0] + 1'b1) : r_den_mag[W-1:0];

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_an        = r_an;
        n_ad        = r_ad;
        n_bn        = r_bn;
        n_bd        = r_bd;
        n_num_mag   = r_num_mag;
        n_num_neg   = r_num_neg;
        n_t2_mag    = r_t2_mag;
        n_t2_neg    = r_t2_neg;
        n_den_mag   = r_den_mag;
        n_den_neg   = r_den_neg;
        n_u         = r_u;
        n_v         = r_v;
        n_k         = r_k;
        n_g         = r_g;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_res_num   = r_res_num;
        n_res_den   = r_res_den;
        n_status    = r_status;

        // Drop the output word once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_func  = i_in.func;
                    n_an    = in_an;
                    n_ad    = in_ad;
                    n_bn    = in_bn;
                    n_bd    = in_bd;
                    n_err   = (in_ad.mag == '0) || (in_bd.mag == '0) ||
                              ((i_in.func == rar_pkg::FUNC_DIV) && (in_bn.mag == '0));
                    n_state = n_err ? S_OUT : S_MUL0;
                end
            end
            S_MUL0: begin
                n_num_mag = mul_p;
                n_num_neg = mul_neg;
                n_state   = ((r_func == rar_pkg::FUNC_MUL) || (r_func == rar_pkg::FUNC_DIV))
                            ? S_MUL2 : S_MUL1;
            end
            S_MUL1: begin
                n_t2_mag = mul_p;
                n_t2_neg = (mul_a.neg ^ mul_b.neg ^ (r_func == rar_pkg::FUNC_SUB)) &&
                           (mul_p != '0);
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                n_den_mag = mul_p;
                n_den_neg = mul_neg;
                n_state   = ((r_func == rar_pkg::FUNC_ADD) || (r_func == rar_pkg::FUNC_SUB))
                            ? S_ADD : S_GINIT;
            end
            S_ADD: begin
                if (!alu_sub) begin
                    n_num_mag = alu_v;
                    n_num_neg = r_num_neg && (alu_v != '0);
                    n_state   = S_GINIT;
                end else if (!alu_c) begin
                    n_num_mag = alu_v;
                    n_num_neg = r_num_neg && (alu_v != '0);
                    n_state   = S_GINIT;
                end else begin
                    // Second term is larger: subtract the other way round
                    n_state = S_ADD2;
                end
            end
            S_ADD2: begin
                n_num_mag = alu_v;
                n_num_neg = r_t2_neg;
                n_state   = S_GINIT;
            end
            S_GINIT: begin
                n_u     = r_num_mag;
                n_v     = r_den_mag;
                n_k     = '0;
                n_state = S_GCD;
            end
            S_GCD: begin
                if ((r_u == '0) || (r_v == '0)) begin
                    n_state = S_SCALE;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (!alu_c) begin
                    // Both odd, u >= v: the difference is even
                    n_u = alu_v >> 1;
                end else begin
                    n_u = r_v;
                    n_v = r_u;
                end
            end
            S_SCALE: begin
                n_g     = (r_u | r_v) << r_k;
                n_rem   = '0;
                n_quo   = r_num_mag;
                n_cnt   = CW'(MW - 1);
                n_state = S_DIVN;
            end
            S_DIVN: begin
                n_rem = div_rem;
                n_quo = div_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_num_mag = div_quo;
                    n_rem     = '0;
                    n_quo     = r_den_mag;
                    n_cnt     = CW'(MW - 1);
                    n_state   = S_DIVD;
                end
            end
            S_DIVD: begin
                n_rem = div_rem;
                n_quo = div_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_den_mag = div_quo;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_err) begin
                        n_res_num = '0;
                        n_res_den = '0;
                        n_status  = rar_pkg::STATUS_ERR;
                    end else if (!num_fits || !den_fits) begin
                        n_res_num = '0;
                        n_res_den = '0;
                        n_status  = rar_pkg::STATUS_OVF;
                    end else begin
                        n_res_num = DB'(num_w);
                        n_res_den = DB'(den_w);
                        n_status  = rar_pkg::STATUS_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_an      <= n_an;
        r_ad      <= n_ad;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_num_mag <= n_num_mag;
        r_num_neg <= n_num_neg;
        r_t2_mag  <= n_t2_mag;
        r_t2_neg  <= n_t2_neg;
        r_den_mag <= n_den_mag;
        r_den_neg <= n_den_neg;
        r_u       <= n_u;
        r_v       <= n_v;
        r_k       <= n_k;
        r_g       <= n_g;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_err     <= n_err;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_status  <= n_status;
    end

    `RAR_ASSERT_NEXT(a_busy_after_accept, in_fire, r_state != S_IDLE,
        "sequencer idle right after accepting a word")
    `RAR_ASSERT_NOW(a_gcd_nonzero, r_state == S_GCD, (r_u != '0) || (r_v != '0),
        "GCD operands both zero")
    `RAR_ASSERT_NOW(a_rem_below_divisor, (r_state == S_DIVN) || (r_state == S_DIVD),
        r_rem < r_g, "divider remainder not below GCD")
    `RAR_ASSERT_NOW(a_fault_zero_fields,
        r_out_valid && (r_status != rar_pkg::STATUS_OK),
        (r_res_num == '0) && (r_res_den == '0), "fault word carries nonzero fields")
    `RAR_ASSERT_NOW(a_ok_den_nonzero,
        r_out_valid && (r_status == rar_pkg::STATUS_OK), r_res_den != '0,
        "ok word with zero denominator")

endmodule

`default_nettype wire
